FILE: hdl/hsvcs_pkg.sv
// ----------------------------------------------------------------------------
// HSV color segmentation package
// Shared types, constants and register indexes of the HSV segmentation pipe.
// ----------------------------------------------------------------------------
package hsvcs_pkg;

    localparam int CHAN_W     = 8;
    localparam int QUOT_W     = 8;
    localparam int BITS_STAGE = 2;
    localparam int DIV_STAGES = QUOT_W / BITS_STAGE;
    localparam int HUE_W      = 11;
    localparam int HNUM_W     = 17;
    localparam int CFG_IDX_W  = 3;

    localparam logic [6:0] HUE_SCALE = 7'd85;

    localparam logic [1:0] SECT_RED   = 2'd0;
    localparam logic [1:0] SECT_GREEN = 2'd1;
    localparam logic [1:0] SECT_BLUE  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_RED_HUE_BELOW = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RED_HUE_ABOVE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RED_SAT_MIN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RED_VAL_MIN   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BLUE_HUE_LOW  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BLUE_HUE_HIGH = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_BLUE_SAT_MIN  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_BLUE_VAL_MIN  = 3'd7;

    typedef struct packed {
        logic [CHAN_W-1:0] blue_in;
        logic [CHAN_W-1:0] green_in;
        logic [CHAN_W-1:0] red_in;
    } hsvcs_pixel_t;

    typedef struct packed {
        logic [CHAN_W-1:0] hue_out;
        logic [CHAN_W-1:0] sat_out;
        logic [CHAN_W-1:0] val_out;
        logic              red_hit;
        logic              blue_hit;
    } hsvcs_result_t;

    typedef struct packed {
        logic [CHAN_W:0]   hue_rem;
        logic [CHAN_W-1:0] hue_low;
        logic [CHAN_W:0]   hue_div;
        logic [QUOT_W-1:0] hue_q;
        logic              hue_zero;
        logic [CHAN_W-1:0] sat_rem;
        logic [CHAN_W-1:0] sat_low;
        logic [CHAN_W-1:0] sat_div;
        logic [QUOT_W-1:0] sat_q;
        logic              sat_zero;
        logic [CHAN_W-1:0] val;
    } hsvcs_div_t;

endpackage

FILE: hdl/hsvcs_front.sv
// ----------------------------------------------------------------------------
// HSV front end
// Three stages: channel extremes and sector, wrapped hue numerator, and the
// scaled dividends that seed the two dividers.
// ----------------------------------------------------------------------------
module hsvcs_front
    import hsvcs_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    input  hsvcs_pixel_t pixel,
    output logic         out_valid,
    output hsvcs_div_t   out_data
);

    logic              s1_valid_reg;
    logic [CHAN_W-1:0] s1_mx_reg, s1_c_reg;
    logic [1:0]        s1_sect_reg;
    logic signed [CHAN_W:0] s1_diff_reg;

    logic [CHAN_W-1:0] mx_next, mn_next;
    logic [1:0]        sect_next;
    logic signed [CHAN_W:0] diff_next;
    logic signed [CHAN_W:0] b_s, g_s, r_s;

    always_comb
    begin
        b_s = $signed({1'b0, pixel.blue_in});
        g_s = $signed({1'b0, pixel.green_in});
        r_s = $signed({1'b0, pixel.red_in});
        mx_next = pixel.red_in;
        if (pixel.green_in > mx_next)
        begin
            mx_next = pixel.green_in;
        end
        if (pixel.blue_in > mx_next)
        begin
            mx_next = pixel.blue_in;
        end
        mn_next = pixel.red_in;
        if (pixel.green_in < mn_next)
        begin
            mn_next = pixel.green_in;
        end
        if (pixel.blue_in < mn_next)
        begin
            mn_next = pixel.blue_in;
        end
        if (mx_next == pixel.blue_in)
        begin
            sect_next = SECT_BLUE;
            diff_next = r_s - g_s;
        end
        else if (mx_next == pixel.green_in)
        begin
            sect_next = SECT_GREEN;
            diff_next = b_s - r_s;
        end
        else
        begin
            sect_next = SECT_RED;
            diff_next = g_s - b_s;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_mx_reg   <= mx_next;
        s1_c_reg    <= mx_next - mn_next;
        s1_sect_reg <= sect_next;
        s1_diff_reg <= diff_next;
    end

    logic              s2_valid_reg;
    logic [CHAN_W-1:0] s2_mx_reg, s2_c_reg;
    logic [HUE_W-1:0]  s2_h_reg;

    logic [HUE_W-1:0]        base;
    logic [HUE_W-1:0]        six_c;
    logic signed [HUE_W:0]   h_sum;
    logic signed [HUE_W:0]   h_next;

    always_comb
    begin
        six_c = {1'b0, s1_c_reg, 2'b00} + {2'b00, s1_c_reg, 1'b0};
        case (s1_sect_reg)
            SECT_BLUE:  base = {1'b0, s1_c_reg, 2'b00};
            SECT_GREEN: base = {2'b00, s1_c_reg, 1'b0};
            default:    base = '0;
        endcase
        h_sum = $signed({1'b0, base}) + {{(HUE_W-CHAN_W){s1_diff_reg[CHAN_W]}}, s1_diff_reg};
        if (h_sum < 0)
        begin
            h_next = h_sum + $signed({1'b0, six_c});
        end
        else
        begin
            h_next = h_sum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_mx_reg <= s1_mx_reg;
        s2_c_reg  <= s1_c_reg;
        s2_h_reg  <= h_next[HUE_W-1:0];
    end

    logic              s3_valid_reg;
    hsvcs_div_t        s3_data_reg;
    hsvcs_div_t        s3_data_next;
    logic [HNUM_W-1:0] hnum;
    logic [2*CHAN_W-1:0] snum;

    always_comb
    begin
        hnum = {{(HNUM_W-HUE_W){1'b0}}, s2_h_reg} *
               {{(HNUM_W-$bits(HUE_SCALE)){1'b0}}, HUE_SCALE};
        snum = {s2_c_reg, {CHAN_W{1'b0}}} - {{CHAN_W{1'b0}}, s2_c_reg};
        s3_data_next.hue_rem  = hnum[HNUM_W-1:CHAN_W];
        s3_data_next.hue_low  = hnum[CHAN_W-1:0];
        s3_data_next.hue_div  = {s2_c_reg, 1'b0};
        s3_data_next.hue_q    = '0;
        s3_data_next.hue_zero = (s2_c_reg == '0);
        s3_data_next.sat_rem  = snum[2*CHAN_W-1:CHAN_W];
        s3_data_next.sat_low  = snum[CHAN_W-1:0];
        s3_data_next.sat_div  = s2_mx_reg;
        s3_data_next.sat_q    = '0;
        s3_data_next.sat_zero = (s2_mx_reg == '0);
        s3_data_next.val      = s2_mx_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s3_data_reg <= s3_data_next;
    end

    assign out_valid = s3_valid_reg;
    assign out_data  = s3_data_reg;

endmodule

FILE: hdl/hsvcs_div_stage.sv
// ----------------------------------------------------------------------------
// HSV divider stage
// Retires BITS_STAGE (two) quotient bits of both the hue and the saturation
// long divisions, then registers the partial state.
// ----------------------------------------------------------------------------
module hsvcs_div_stage
    import hsvcs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  hsvcs_div_t in_data,
    output logic       out_valid,
    output hsvcs_div_t out_data
);

    logic       valid_reg;
    hsvcs_div_t data_reg;
    hsvcs_div_t data_next;
    logic [CHAN_W+1:0] hue_trial;
    logic [CHAN_W:0]   sat_trial;

    always_comb
    begin
        data_next = in_data;
        for (int i = 0; i < BITS_STAGE; i++)
        begin
            hue_trial = {data_next.hue_rem, data_next.hue_low[CHAN_W-1]};
            if (hue_trial >= {1'b0, data_next.hue_div})
            begin
                data_next.hue_rem = (CHAN_W+1)'(hue_trial - {1'b0, data_next.hue_div});
                data_next.hue_q   = {data_next.hue_q[QUOT_W-2:0], 1'b1};
            end
            else
            begin
                data_next.hue_rem = hue_trial[CHAN_W:0];
                data_next.hue_q   = {data_next.hue_q[QUOT_W-2:0], 1'b0};
            end
            data_next.hue_low = {data_next.hue_low[CHAN_W-2:0], 1'b0};

            sat_trial = {data_next.sat_rem, data_next.sat_low[CHAN_W-1]};
            if (sat_trial >= {1'b0, data_next.sat_div})
            begin
                data_next.sat_rem = CHAN_W'(sat_trial - {1'b0, data_next.sat_div});
                data_next.sat_q   = {data_next.sat_q[QUOT_W-2:0], 1'b1};
            end
            else
            begin
                data_next.sat_rem = sat_trial[CHAN_W-1:0];
                data_next.sat_q   = {data_next.sat_q[QUOT_W-2:0], 1'b0};
            end
            data_next.sat_low = {data_next.sat_low[CHAN_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

FILE: hdl/hsvcs_classify.sv
// ----------------------------------------------------------------------------
// HSV threshold classifier
// Holds the threshold registers, finishes hue and saturation, compares them
// and value against the thresholds and registers the result transaction.
// ----------------------------------------------------------------------------
module hsvcs_classify
    import hsvcs_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CHAN_W-1:0]    cfg_data,
    input  logic                 in_valid,
    input  hsvcs_div_t           in_data,
    output logic                 done,
    output hsvcs_result_t        result
);

    logic [CHAN_W-1:0] red_hue_below_reg, red_hue_above_reg;
    logic [CHAN_W-1:0] red_sat_min_reg, red_val_min_reg;
    logic [CHAN_W-1:0] blue_hue_low_reg, blue_hue_high_reg;
    logic [CHAN_W-1:0] blue_sat_min_reg, blue_val_min_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            red_hue_below_reg <= 8'd15;
            red_hue_above_reg <= 8'd215;
            red_sat_min_reg   <= 8'd70;
            red_val_min_reg   <= 8'd70;
            blue_hue_low_reg  <= 8'd140;
            blue_hue_high_reg <= 8'd185;
            blue_sat_min_reg  <= 8'd110;
            blue_val_min_reg  <= 8'd100;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_RED_HUE_BELOW: red_hue_below_reg <= cfg_data;
                REG_RED_HUE_ABOVE: red_hue_above_reg <= cfg_data;
                REG_RED_SAT_MIN:   red_sat_min_reg   <= cfg_data;
                REG_RED_VAL_MIN:   red_val_min_reg   <= cfg_data;
                REG_BLUE_HUE_LOW:  blue_hue_low_reg  <= cfg_data;
                REG_BLUE_HUE_HIGH: blue_hue_high_reg <= cfg_data;
                REG_BLUE_SAT_MIN:  blue_sat_min_reg  <= cfg_data;
                REG_BLUE_VAL_MIN:  blue_val_min_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    logic          done_reg;
    hsvcs_result_t result_reg;
    hsvcs_result_t result_next;

    always_comb
    begin
        result_next.hue_out = in_data.hue_zero ? '0 : in_data.hue_q;
        result_next.sat_out = in_data.sat_zero ? '0 : in_data.sat_q;
        result_next.val_out = in_data.val;
        result_next.red_hit = ((result_next.hue_out < red_hue_below_reg) ||
                               (result_next.hue_out > red_hue_above_reg)) &&
                              (result_next.sat_out > red_sat_min_reg) &&
                              (result_next.val_out > red_val_min_reg);
        result_next.blue_hit = (result_next.hue_out >= blue_hue_low_reg) &&
                               (result_next.hue_out <= blue_hue_high_reg) &&
                               (result_next.sat_out > blue_sat_min_reg) &&
                               (result_next.val_out > blue_val_min_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

FILE: hdl/hsv_color_segment_top.sv
// ----------------------------------------------------------------------------
// HSV color segmentation top level
// Converts one BGR pixel per clock to hue, saturation and value and flags
// pixels that pass the red and blue threshold windows.
// Throughput is one pixel per cycle, through an eight-register pipeline (three
// front stages, four divider stages, output). busy is always low. Reset clears
// all valid bits and loads the default thresholds; results must be taken in
// the cycle they are shown.
// ----------------------------------------------------------------------------
module hsv_color_segment_top
    import hsvcs_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  hsvcs_pixel_t         pixel,
    output logic                 done,
    output hsvcs_result_t        result,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CHAN_W-1:0]    cfg_data
);

    logic                  accept;
    logic [DIV_STAGES:0]   div_valid;
    hsvcs_div_t            div_data [0:DIV_STAGES];

    assign busy   = 1'b0;
    assign accept = start && !busy;

    hsvcs_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .pixel     (pixel),
        .out_valid (div_valid[0]),
        .out_data  (div_data[0])
    );

    for (genvar k = 0; k < DIV_STAGES; k++)
    begin : g_div
        hsvcs_div_stage u_div_stage
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (div_valid[k]),
            .in_data   (div_data[k]),
            .out_valid (div_valid[k+1]),
            .out_data  (div_data[k+1])
        );
    end

    hsvcs_classify u_classify
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (div_valid[DIV_STAGES]),
        .in_data   (div_data[DIV_STAGES]),
        .done      (done),
        .result    (result)
    );

endmodule

FILE: hdl/hsvcs_checker.sv
// ----------------------------------------------------------------------------
// HSV segmentation port checker
// Watches the top level's ports for result timing and result consistency.
// ----------------------------------------------------------------------------
module hsvcs_checker
    import hsvcs_pkg::*;
(
    input logic          clk,
    input logic          rst_n,
    input logic          start,
    input logic          busy,
    input logic          done,
    input hsvcs_result_t result
);

    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy was raised");

    a_done_follows_start: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, 8))
        else $error("result transaction without a matching start");

    a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.hue_out != 8'd255))
        else $error("hue out of range");

    a_black_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.val_out == '0)) |-> (result.sat_out == '0))
        else $error("nonzero saturation for a black pixel");

    a_grey_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.sat_out == '0)) |-> (result.hue_out == '0))
        else $error("nonzero hue for a pixel without chroma");

endmodule

bind hsv_color_segment_top hsvcs_checker u_hsvcs_checker
(
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);
